@@ sv/rgb_triplet_text_parser_unit_assert.svh @@
// Assertion macros for the RGB triplet text parser.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef RGB_TRIPLET_TEXT_PARSER_UNIT_ASSERT_SVH
`define RGB_TRIPLET_TEXT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define RGBTP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RGBTP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rgbtp_pkg.sv @@
// Shared types and constants for the RGB triplet text parser.
// No dependencies.
package rgbtp_pkg;

   localparam int NUM_COMPONENTS = 3;
   localparam int MAX_COMPONENT  = 255;
   localparam int STORE_DEPTH    = 4;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_BAD_CHAR = 3'd1;
   localparam logic [2:0] STATUS_COUNT    = 3'd2;
   localparam logic [2:0] STATUS_EMPTY    = 3'd3;
   localparam logic [2:0] STATUS_JUNK     = 3'd4;
   localparam logic [2:0] STATUS_RANGE    = 3'd5;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] character;
      logic       final_char;
   } rgbtp_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] status;
   } rgbtp_rsp_type;

endpackage

@@ sv/rgb_triplet_text_parser_unit.sv @@
// RGB triplet text parser: top level, single module.
// Depends on rgbtp_pkg and rgb_triplet_text_parser_unit_assert.svh.
//
// Usage:
//  A text line streams in on the req_ channel, one character per request,
//  with final_char set on the last character. Commas split the line into
//  pieces; each piece holds an optional run of spaces/tabs, then decimal
//  digits, then optional whitespace. On the final character one response
//  appears on the rsp_ channel with red, green, blue and a status code;
//  other characters produce no response.
//  Latency: the response is valid the cycle after the final character is
//  accepted. Throughput: one character per cycle; the per-character update
//  (phase decode, accumulate by ten, piece close) is short combinational
//  logic between the parse state registers and the response register.
//  Stall: a held response keeps its payload; req_stall rises only while a
//  response is pending and rsp_stall is high, so no request is taken while
//  a response waits.
//  Reset: synchronous, active high; clears the parse state and drops
//  rsp_valid. Parse state also returns to idle after every final character.
module rgb_triplet_text_parser_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rgbtp_pkg::rgbtp_req_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rgbtp_pkg::rgbtp_rsp_type rsp_payload
);
   import rgbtp_pkg::*;

   `include "rgb_triplet_text_parser_unit_assert.svh"

   // piece phase codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_TRAIL  = 3'd3;
   localparam logic [2:0] PH_WSONLY = 3'd4;
   localparam logic [2:0] PH_JUNK   = 3'd5;

   localparam logic [8:0] ACC_SAT   = 9'd256;
   localparam logic [8:0] MAX_VAL   = 9'(MAX_COMPONENT);
   localparam logic [2:0] COUNT_SAT = 3'd7;
   localparam logic [2:0] NUM_COMP  = 3'(NUM_COMPONENTS);

   logic [2:0]    phase_ff, phase_in;
   logic [8:0]    accum_ff, accum_in;
   logic [2:0]    count_ff, count_in;
   logic          bad_ff, bad_in;
   logic [2:0]    fpe_ff, fpe_in;
   logic [7:0]    store_ff [STORE_DEPTH];
   logic          store_we;
   logic [1:0]    store_idx;
   logic [7:0]    store_val;
   logic          rsp_valid_ff, rsp_valid_in;
   rgbtp_rsp_type rsp_ff, rsp_in;
   logic          req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      logic [7:0]  c;
      logic        last;
      logic        is_comma, is_digit, is_sptab, is_other_ws;
      logic [2:0]  ph_mid;
      logic [8:0]  acc_mid;
      logic        bad_mid;
      logic [11:0] acc_wide;
      logic [2:0]  cnt_cl;
      logic [2:0]  fpe_cl;
      logic [2:0]  err;
      logic [2:0]  status;
      logic [7:0]  comp [STORE_DEPTH];

      c           = req_payload.character;
      last        = req_payload.final_char;
      is_comma    = (c == CHAR_COMMA);
      is_digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_sptab    = (c == CHAR_SPACE) || (c == CHAR_TAB);
      is_other_ws = (c >= CHAR_LF) && (c <= CHAR_CR);

      // character step
      ph_mid   = phase_ff;
      acc_mid  = accum_ff;
      bad_mid  = bad_ff;
      acc_wide = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0} + {8'd0, c[3:0]};
      if (is_comma) begin
         ph_mid = phase_ff;
      end else if (is_digit) begin
         if (phase_ff == PH_IDLE || phase_ff == PH_LEAD) begin
            ph_mid  = PH_DIGITS;
            acc_mid = {5'd0, c[3:0]};
         end else if (phase_ff == PH_DIGITS) begin
            acc_mid = (acc_wide > {3'd0, ACC_SAT}) ? ACC_SAT : acc_wide[8:0];
         end else begin
            ph_mid = PH_JUNK;
         end
      end else if (is_sptab || is_other_ws) begin
         if (phase_ff == PH_IDLE || phase_ff == PH_LEAD) begin
            ph_mid = is_sptab ? PH_LEAD : PH_WSONLY;
         end else if (phase_ff == PH_DIGITS) begin
            ph_mid = PH_TRAIL;
         end
      end else begin
         bad_mid = 1'b1;
         ph_mid  = PH_JUNK;
      end

      // piece close on comma or end of line
      cnt_cl    = count_ff;
      fpe_cl    = fpe_ff;
      store_we  = 1'b0;
      store_idx = count_ff[1:0];
      store_val = 8'd0;
      err       = STATUS_OK;
      if ((is_comma || last) && ph_mid != PH_IDLE) begin
         if (count_ff != COUNT_SAT) begin
            cnt_cl = count_ff + 3'd1;
         end
         if (count_ff < NUM_COMP && fpe_ff == STATUS_OK) begin
            unique case (ph_mid)
               PH_LEAD: err = STATUS_EMPTY;
               PH_JUNK: err = STATUS_JUNK;
               PH_DIGITS, PH_TRAIL: begin
                  if (acc_mid > MAX_VAL) begin
                     err = STATUS_RANGE;
                  end else begin
                     store_val = acc_mid[7:0];
                  end
               end
               default: err = STATUS_OK;
            endcase
            if (err != STATUS_OK) begin
               fpe_cl = err;
            end else begin
               store_we = 1'b1;
            end
         end
      end

      for (int i = 0; i < STORE_DEPTH; i++) begin
         comp[i] = (store_we && store_idx == 2'(i)) ? store_val : store_ff[i];
      end

      if (bad_mid) begin
         status = STATUS_BAD_CHAR;
      end else if (cnt_cl != NUM_COMP) begin
         status = STATUS_COUNT;
      end else begin
         status = fpe_cl;
      end

      rsp_in.status = status;
      rsp_in.red    = (status == STATUS_OK) ? comp[0] : 8'd0;
      rsp_in.green  = (status == STATUS_OK && NUM_COMPONENTS > 1) ? comp[1] : 8'd0;
      rsp_in.blue   = (status == STATUS_OK && NUM_COMPONENTS > 2) ? comp[2] : 8'd0;

      // next parse state
      if (last) begin
         phase_in = PH_IDLE;
         accum_in = 9'd0;
         count_in = 3'd0;
         bad_in   = 1'b0;
         fpe_in   = STATUS_OK;
      end else if (is_comma) begin
         phase_in = PH_IDLE;
         accum_in = 9'd0;
         count_in = cnt_cl;
         bad_in   = bad_mid;
         fpe_in   = fpe_cl;
      end else begin
         phase_in = ph_mid;
         accum_in = acc_mid;
         count_in = count_ff;
         bad_in   = bad_mid;
         fpe_in   = fpe_ff;
      end

      rsp_valid_in = (req_accept && last) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         accum_ff     <= 9'd0;
         count_ff     <= 3'd0;
         bad_ff       <= 1'b0;
         fpe_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            count_ff <= count_in;
            bad_ff   <= bad_in;
            fpe_ff   <= fpe_in;
         end
      end
   end

   // component store: read only when slots 0-2 were all written this line
   always_ff @(posedge clock) begin
      if (req_accept && store_we) begin
         store_ff[store_idx] <= store_val;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_payload.final_char) begin
         rsp_ff <= rsp_in;
      end
   end

   `RGBTP_ASSERT_NEXT(a_final_gives_rsp, req_accept && req_payload.final_char, rsp_valid_ff, "final character did not produce a response")
   `RGBTP_ASSERT_NEXT(a_final_clears_state, req_accept && req_payload.final_char, phase_ff == PH_IDLE && count_ff == 3'd0 && !bad_ff && fpe_ff == STATUS_OK, "parse state not cleared after final character")
   `RGBTP_ASSERT_SAME(a_error_zero_colors, rsp_valid_ff && rsp_ff.status != STATUS_OK, rsp_ff.red == 8'd0 && rsp_ff.green == 8'd0 && rsp_ff.blue == 8'd0, "nonzero component with error status")

endmodule

@@ tb/rgb_triplet_text_parser_unit_tb.sv @@
// Testbench for rgb_triplet_text_parser_unit: streams colour lines and checks each response.
// Predicts every response with a local scoreboard model of the parser.
// Depends on rgbtp_pkg and the DUT sources.
`timescale 1ns / 100ps

import rgbtp_pkg::*;

typedef enum logic [2:0] {
   PH_IDLE, PH_LEAD, PH_DIGITS, PH_TRAIL, PH_WSONLY, PH_JUNK
} piece_phase_type;

class rgb_line_scoreboard;
   piece_phase_type phase;
   logic [8:0]    accum;
   logic [2:0]    piece_cnt;
   logic [7:0]    comp [STORE_DEPTH];
   bit            bad_seen;
   logic [2:0]    piece_err;
   rgbtp_rsp_type expected_q [$];
   int            errors;

   function new();
      errors = 0;
      clear_line();
   endfunction

   function void clear_line();
      phase     = PH_IDLE;
      accum     = '0;
      piece_cnt = '0;
      foreach (comp[i]) comp[i] = '0;
      bad_seen  = 1'b0;
      piece_err = STATUS_OK;
   endfunction

   function void close_piece();
      int         idx;
      logic [2:0] err;
      logic [7:0] val;
      if (phase == PH_IDLE) return;
      idx = piece_cnt;
      err = STATUS_OK;
      val = '0;
      if (piece_cnt != 3'd7) piece_cnt++;
      // only the first pieces are checked, and only until one fails
      if (idx < NUM_COMPONENTS && idx < STORE_DEPTH && piece_err == STATUS_OK) begin
         case (phase)
            PH_LEAD: err = STATUS_EMPTY;
            PH_JUNK: err = STATUS_JUNK;
            PH_DIGITS, PH_TRAIL: begin
               if (accum > MAX_COMPONENT) err = STATUS_RANGE;
               else val = accum[7:0];
            end
            default: ;
         endcase
         if (err != STATUS_OK) piece_err = err;
         else comp[idx] = val;
      end
      phase = PH_IDLE;
      accum = '0;
   endfunction

   function void note_request(rgbtp_req_type req);
      logic [7:0]    ch;
      int            grown;
      rgbtp_rsp_type want;
      ch = req.character;
      if (ch == CHAR_COMMA) begin
         close_piece();
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         if (phase == PH_IDLE || phase == PH_LEAD) begin
            phase = PH_DIGITS;
            accum = 9'(ch - CHAR_ZERO);
         end else if (phase == PH_DIGITS) begin
            grown = int'(accum) * 10 + int'(ch - CHAR_ZERO);
            accum = (grown > 256) ? 9'd256 : 9'(grown);
         end else begin
            phase = PH_JUNK;
         end
      end else if (ch == CHAR_SPACE || ch == CHAR_TAB || (ch >= CHAR_LF && ch <= CHAR_CR)) begin
         if (phase == PH_IDLE || phase == PH_LEAD)
            phase = (ch == CHAR_SPACE || ch == CHAR_TAB) ? PH_LEAD : PH_WSONLY;
         else if (phase == PH_DIGITS)
            phase = PH_TRAIL;
      end else begin
         bad_seen = 1'b1;
         phase    = PH_JUNK;
      end
      if (!req.final_char) return;
      close_piece();
      want = '0;
      if (bad_seen) want.status = STATUS_BAD_CHAR;
      else if (piece_cnt != NUM_COMPONENTS) want.status = STATUS_COUNT;
      else want.status = piece_err;
      if (want.status == STATUS_OK) begin
         want.red   = comp[0];
         want.green = comp[1];
         want.blue  = comp[2];
      end
      expected_q.push_back(want);
      clear_line();
   endfunction

   function void check_response(rgbtp_rsp_type got);
      rgbtp_rsp_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: response with none expected: red=%0d green=%0d blue=%0d status=%0d",
                  $time, got.red, got.green, got.blue, got.status);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red) begin
         $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
         errors++;
      end
      if (got.green !== want.green) begin
         $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
         errors++;
      end
      if (got.blue !== want.blue) begin
         $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
         errors++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module rgb_triplet_text_parser_unit_tb;
   typedef logic [7:0] char_q_type [$];

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   rgbtp_req_type req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   rgbtp_rsp_type rsp_payload;

   rgb_line_scoreboard lines_sb;
   bit idle_on      = 1'b1;
   int hold_req_cnt = 0;
   int sent_chars   = 0;

   rgb_triplet_text_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic char_q_type str_bytes(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] ws_char();
      case ($urandom_range(0, 2))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         default: return 8'(CHAR_LF + $urandom_range(0, 3));  // LF, VT, FF, CR
      endcase
   endfunction

   // mostly well-formed lines with random values; some corrupted, some pure noise
   function automatic char_q_type random_line();
      char_q_type txt;
      char_q_type num;
      int      mode;
      int      npieces;
      int      v;
      int      pos;
      mode = $urandom_range(0, 11);
      if (mode == 11) begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
               0: txt.push_back(8'($urandom_range(0, 255)));
               1: txt.push_back(CHAR_COMMA);
               2: txt.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
               default: txt.push_back(ws_char());
            endcase
         end
         return txt;
      end
      npieces = (mode == 10) ? $urandom_range(0, 5) : NUM_COMPONENTS;
      for (int p = 0; p < npieces; p++) begin
         if ($urandom_range(0, 7) == 0) txt.push_back(CHAR_COMMA);
         repeat ($urandom_range(0, 2)) txt.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         case ($urandom_range(0, 7))
            0: v = $urandom_range(256, 99999);
            1: v = $urandom_range(0, 9);
            default: v = $urandom_range(0, 255);
         endcase
         if ($urandom_range(0, 7) == 0) txt.push_back(CHAR_ZERO);
         num = str_bytes($sformatf("%0d", v));
         foreach (num[i]) txt.push_back(num[i]);
         repeat ($urandom_range(0, 2)) txt.push_back(ws_char());
         if (p != npieces - 1 || $urandom_range(0, 7) == 0) txt.push_back(CHAR_COMMA);
      end
      if (txt.size() == 0) txt.push_back(CHAR_COMMA);
      if (mode == 8 || mode == 9) begin
         pos = $urandom_range(0, txt.size() - 1);
         case ($urandom_range(0, 2))
            0: txt[pos] = 8'($urandom_range(0, 255));
            1: txt[pos] = ws_char();
            default: txt.insert(pos, 8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
         endcase
      end
      return txt;
   endfunction

   task automatic send_char(logic [7:0] ch, logic fin);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{character: ch, final_char: fin};
      do @(posedge clock); while (req_stall);
      lines_sb.note_request(req_payload);
      sent_chars++;
   endtask

   task automatic send_line(char_q_type txt);
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
   endtask

   // sender pause: nothing offered until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (lines_sb.pending() != 0) @(posedge clock);
   endtask

   // response side
   initial begin
      int wait_left;
      int hold_left;
      int holds_done;
      wait_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            lines_sb.check_response(rsp_payload);
            wait_left = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (holds_done != hold_req_cnt) begin
            holds_done = hold_req_cnt;
            hold_left  = $urandom_range(100, 300);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      char_q_type txt;
      int      lines;
      lines_sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_line(str_bytes("0,0,0"));
      send_line(str_bytes("255,255,255"));
      send_line(str_bytes(" 12 ,\t34\t,  56\t"));
      send_line(str_bytes(",,7,,8,,9,,"));           // empty pieces dropped
      send_line(str_bytes("256,1,2"));
      send_line(str_bytes("1,99999999,2"));          // accumulator saturates
      send_line(str_bytes("1,2"));
      send_line(str_bytes("1,2,3,4"));
      send_line(str_bytes("1, \t ,3"));              // blank piece
      send_line(str_bytes("1 2,3,4"));               // digit after whitespace
      send_line(str_bytes("\n5,1,2"));               // digit after LF
      send_line(str_bytes("300 1,2,3"));             // junk wins over range
      send_line(str_bytes("\n,\v,\f\015"));          // other whitespace only: zeros
      send_line(str_bytes("1,300,  "));              // first failing piece wins
      send_line(str_bytes("1,2,x"));
      send_line(str_bytes("1,2,3,x"));               // bad char beats count
      txt = str_bytes("1,2,");
      txt.push_back(8'h00);
      send_line(txt);
      txt = str_bytes("9,8,7");
      txt.push_back(8'hFF);
      send_line(txt);
      send_line(str_bytes("5"));
      send_line(str_bytes(","));
      send_line(str_bytes("007,08,9,"));
      drain();

      // receiver holds off while lines keep coming back to back
      idle_on = 1'b0;
      hold_req_cnt++;
      repeat (12) send_line(str_bytes("7,8,9"));
      idle_on = 1'b1;
      drain();

      lines = 0;
      while (sent_chars < 1400) begin
         idle_on = ($urandom_range(0, 3) != 0);
         send_line(random_line());
         lines++;
         if (lines % 61 == 0) hold_req_cnt++;
         if (lines % 37 == 0) drain();
      end
      idle_on = 1'b1;
      drain();
      repeat (10) @(posedge clock);
      if (lines_sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+sv
sv/rgbtp_pkg.sv
sv/rgb_triplet_text_parser_unit.sv
tb/rgb_triplet_text_parser_unit_tb.sv
